[rtl/i2cmrt_pkg.sv]
package i2cmrt_pkg;

    // Defaults for the top-level parameters.
    localparam int SUBADDR_MAX_BYTES_DEF = 4;
    localparam int COUNT_BITS_DEF        = 16;

    // Item kinds.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_SUB    = 3'd2;
    localparam logic [2:0] PH_RSTART = 3'd3;
    localparam logic [2:0] PH_WRITE  = 3'd4;
    localparam logic [2:0] PH_READ   = 3'd5;

    // Bus commands.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_SEND   = 3'd2;
    localparam logic [2:0] CMD_RSTART = 3'd3;
    localparam logic [2:0] CMD_RECV   = 3'd4;
    localparam logic [2:0] CMD_STOP   = 3'd5;

    // Transfer status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_ARB     = 3'd2;
    localparam logic [2:0] ST_NAK     = 3'd3;
    localparam logic [2:0] ST_ADDRNAK = 3'd4;

    typedef struct packed {
        logic        op;
        logic [6:0]  slave_addr;
        logic        is_read;
        logic [31:0] sub_addr;
        logic [2:0]  sub_addr_bytes;
        logic [15:0] data_count;
        logic        bus_busy;
        logic        nak_seen;
        logic        arb_lost;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] bus_byte;
        logic       nak_next;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [2:0] status;
        logic       done_res;
    } result_t;

    // One step of the sequencer: whether it produced a result beat, and the beat.
    typedef struct packed {
        logic    valid;
        result_t res;
    } step_res_t;

endpackage

[rtl/i2cmrt_seq.sv]
module i2cmrt_seq #(
    parameter int SUBADDR_MAX_BYTES = i2cmrt_pkg::SUBADDR_MAX_BYTES_DEF,
    parameter int COUNT_BITS        = i2cmrt_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  i2cmrt_pkg::item_t     item,
    output i2cmrt_pkg::step_res_t step
);

    localparam int LW = $clog2(SUBADDR_MAX_BYTES + 1);
    localparam int CW = COUNT_BITS;
    localparam logic [3:0] MAX4 = 4'(SUBADDR_MAX_BYTES);

    logic [2:0]    phase_reg, phase_next;
    logic [6:0]    target_addr_reg, target_addr_next;
    logic          read_mode_reg, read_mode_next;
    logic [31:0]   subaddr_reg, subaddr_next;
    logic [LW-1:0] sub_left_reg, sub_left_next;
    logic [CW-1:0] bytes_left_reg, bytes_left_next;

    logic [3:0]    n4;
    logic [3:0]    nsat4;
    logic [31:0]   count_wide;
    logic [LW-1:0] left_dec;
    logic [3:0]    left_dec4;
    logic [7:0]    sub_byte;
    logic [CW-1:0] bytes_dec;
    logic [2:0]    err;
    logic [2:0]    dp_phase;
    i2cmrt_pkg::result_t dp_res;
    i2cmrt_pkg::result_t res;
    logic          res_valid;

    assign n4         = {1'b0, item.sub_addr_bytes};
    assign nsat4      = (n4 > MAX4) ? MAX4 : n4;
    assign count_wide = {16'h0000, item.data_count};
    assign left_dec   = sub_left_reg - LW'(1);
    assign left_dec4  = 4'(left_dec);
    assign sub_byte   = (left_dec4 < 4'd4) ? 8'(subaddr_reg >> {left_dec4[1:0], 3'b000}) : 8'h00;
    assign bytes_dec  = bytes_left_reg - CW'(1);
    assign err        = item.arb_lost ? i2cmrt_pkg::ST_ARB
                      : (item.nak_seen ? i2cmrt_pkg::ST_NAK : i2cmrt_pkg::ST_OK);

    // Entry to the data phase, shared by the address, subaddress and repeated-start phases.
    always_comb
    begin
        dp_res = '0;
        if (bytes_left_reg == '0)
        begin
            dp_phase        = i2cmrt_pkg::PH_IDLE;
            dp_res.cmd      = i2cmrt_pkg::CMD_STOP;
            dp_res.status   = i2cmrt_pkg::ST_OK;
            dp_res.done_res = 1'b1;
        end
        else if (read_mode_reg)
        begin
            dp_phase        = i2cmrt_pkg::PH_READ;
            dp_res.cmd      = i2cmrt_pkg::CMD_RECV;
            dp_res.nak_next = (bytes_left_reg == CW'(1));
        end
        else
        begin
            dp_phase        = i2cmrt_pkg::PH_WRITE;
            dp_res.cmd      = i2cmrt_pkg::CMD_SEND;
            dp_res.bus_byte = item.tx_byte;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        target_addr_next = target_addr_reg;
        read_mode_next   = read_mode_reg;
        subaddr_next     = subaddr_reg;
        sub_left_next    = sub_left_reg;
        bytes_left_next  = bytes_left_reg;
        res              = '0;
        res_valid        = 1'b0;

        if (item.op == i2cmrt_pkg::OP_START)
        begin
            if (phase_reg == i2cmrt_pkg::PH_IDLE)
            begin
                res_valid = 1'b1;
                if (item.bus_busy)
                begin
                    res.cmd      = i2cmrt_pkg::CMD_NONE;
                    res.status   = i2cmrt_pkg::ST_BUSY;
                    res.done_res = 1'b1;
                end
                else
                begin
                    target_addr_next = item.slave_addr;
                    read_mode_next   = item.is_read;
                    subaddr_next     = item.sub_addr;
                    sub_left_next    = LW'(nsat4);
                    bytes_left_next  = count_wide[CW-1:0];
                    phase_next       = i2cmrt_pkg::PH_ADDR;
                    res.cmd          = i2cmrt_pkg::CMD_START;
                    // A read with a subaddress opens with a write address byte.
                    res.bus_byte     = {item.slave_addr, item.is_read && (nsat4 == 4'd0)};
                end
            end
        end
        else
        begin
            unique case (phase_reg) inside
                i2cmrt_pkg::PH_ADDR, i2cmrt_pkg::PH_SUB:
                begin
                    res_valid = 1'b1;
                    if (err != i2cmrt_pkg::ST_OK)
                    begin
                        phase_next   = i2cmrt_pkg::PH_IDLE;
                        res.cmd      = i2cmrt_pkg::CMD_STOP;
                        res.status   = err;
                        res.done_res = 1'b1;
                    end
                    else if (sub_left_reg != '0)
                    begin
                        sub_left_next = left_dec;
                        phase_next    = i2cmrt_pkg::PH_SUB;
                        res.cmd       = i2cmrt_pkg::CMD_SEND;
                        res.bus_byte  = sub_byte;
                    end
                    else if ((phase_reg == i2cmrt_pkg::PH_SUB) && read_mode_reg)
                    begin
                        phase_next   = i2cmrt_pkg::PH_RSTART;
                        res.cmd      = i2cmrt_pkg::CMD_RSTART;
                        res.bus_byte = {target_addr_reg, 1'b1};
                    end
                    else
                    begin
                        phase_next = dp_phase;
                        res        = dp_res;
                    end
                end
                i2cmrt_pkg::PH_RSTART:
                begin
                    res_valid = 1'b1;
                    if (err != i2cmrt_pkg::ST_OK)
                    begin
                        phase_next   = i2cmrt_pkg::PH_IDLE;
                        res.cmd      = i2cmrt_pkg::CMD_STOP;
                        res.status   = i2cmrt_pkg::ST_ADDRNAK;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        phase_next = dp_phase;
                        res        = dp_res;
                    end
                end
                i2cmrt_pkg::PH_WRITE:
                begin
                    res_valid       = 1'b1;
                    bytes_left_next = bytes_dec;
                    // An error on a data byte still finishes with status ok.
                    if ((err != i2cmrt_pkg::ST_OK) || (bytes_dec == '0))
                    begin
                        phase_next   = i2cmrt_pkg::PH_IDLE;
                        res.cmd      = i2cmrt_pkg::CMD_STOP;
                        res.status   = i2cmrt_pkg::ST_OK;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        res.cmd      = i2cmrt_pkg::CMD_SEND;
                        res.bus_byte = item.tx_byte;
                    end
                end
                i2cmrt_pkg::PH_READ:
                begin
                    res_valid       = 1'b1;
                    bytes_left_next = bytes_dec;
                    res.rx_data     = item.rx_byte;
                    res.rx_valid    = 1'b1;
                    if (bytes_dec == '0)
                    begin
                        phase_next   = i2cmrt_pkg::PH_IDLE;
                        res.cmd      = i2cmrt_pkg::CMD_STOP;
                        res.status   = i2cmrt_pkg::ST_OK;
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        res.cmd      = i2cmrt_pkg::CMD_RECV;
                        res.nak_next = (bytes_dec == CW'(1));
                    end
                end
                default:
                begin
                    phase_next = i2cmrt_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cmrt_pkg::PH_IDLE;
            target_addr_reg <= '0;
            read_mode_reg   <= 1'b0;
            subaddr_reg     <= '0;
            sub_left_reg    <= '0;
            bytes_left_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            target_addr_reg <= target_addr_next;
            read_mode_reg   <= read_mode_next;
            subaddr_reg     <= subaddr_next;
            sub_left_reg    <= sub_left_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    assign step.valid = advance && res_valid;
    assign step.res   = res;

endmodule

[rtl/i2cmrt_outq.sv]
module i2cmrt_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cmrt_pkg::step_res_t wr,
    output logic                  room,
    output logic                  rd_valid,
    input  logic                  rd_stall,
    output i2cmrt_pkg::result_t   rd_data
);

    // Two-entry result queue; the writer only pushes while room is high.
    i2cmrt_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push     = wr.valid;
    assign pop      = rd_valid && !rd_stall;
    assign room     = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/i2c_master_register_transfer.sv]
// Byte-level I2C master sequencer for register reads and writes. A start item (op 0)
// carries the target address, direction, a subaddress of up to SUBADDR_MAX_BYTES bytes and
// a data count; each byte-completed item (op 1) reports the acknowledge, arbitration and
// received byte of the byte just finished on the bus, and the block answers with the next
// bus command: start with address, subaddress bytes most significant first, a repeated
// start for subaddressed reads, then data sends or receives, and finally stop carrying
// the transfer status. A start item while the bus is busy returns a single beat with
// status busy; a start item during a transfer and a byte item while idle are dropped
// without a result. The block takes one item beat per clock cycle unless the input stalls.
// Each item is held in an input register, the sequencer step is evaluated combinationally
// from that register, and its result beat is written into a two-entry output queue. The
// input stalls only while the output queue is full and an item is waiting.
module i2c_master_register_transfer #(
    parameter int SUBADDR_MAX_BYTES = i2cmrt_pkg::SUBADDR_MAX_BYTES_DEF,
    parameter int COUNT_BITS        = i2cmrt_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  i2cmrt_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output i2cmrt_pkg::result_t result
);

    // Input register stage.
    logic                  in_vld_reg, in_vld_next;
    i2cmrt_pkg::item_t     in_reg;
    logic                  room;
    logic                  advance;
    logic                  accept;
    i2cmrt_pkg::step_res_t step;

    // The held item moves through the sequencer whenever the queue can take its beat.
    assign advance     = in_vld_reg && room;
    assign item_stall  = in_vld_reg && !room;
    assign accept      = item_valid && !item_stall;
    assign in_vld_next = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

    i2cmrt_seq #(
        .SUBADDR_MAX_BYTES (SUBADDR_MAX_BYTES),
        .COUNT_BITS        (COUNT_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_reg),
        .step    (step)
    );

    i2cmrt_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (step),
        .room     (room),
        .rd_valid (result_valid),
        .rd_stall (result_stall),
        .rd_data  (result)
    );

    // The input side only stalls while it holds an item of its own.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_vld_reg)
        else $error("input stalled with an empty input register");

    // A finishing beat is always a stop, or the bare busy answer.
    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_res) |->
            (result.cmd == i2cmrt_pkg::CMD_STOP || result.cmd == i2cmrt_pkg::CMD_NONE))
        else $error("finishing beat without a stop command");

    // Status is only reported on the finishing beat.
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.done_res) |-> (result.status == i2cmrt_pkg::ST_OK))
        else $error("status reported before the transfer finished");

    // Received data is only handed back with a receive or the closing stop.
    a_rx_with_read: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.rx_valid) |->
            (result.cmd == i2cmrt_pkg::CMD_RECV || result.cmd == i2cmrt_pkg::CMD_STOP))
        else $error("received byte delivered outside the read phase");

endmodule

[bench/i2c_master_register_transfer_tb.sv]
module i2c_master_register_transfer_tb;

    // The slowest honest run is roughly 1600 item beats, each waiting out a full sender
    // gap, a full receiver stall and the pipeline, so this limit leaves plenty of headroom
    // and only catches a hang.
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [2:0] SUB_MAX     = 3'(i2cmrt_pkg::SUBADDR_MAX_BYTES_DEF);

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    i2cmrt_pkg::item_t   item;
    logic                result_valid;
    logic                result_stall;
    i2cmrt_pkg::result_t result;

    i2c_master_register_transfer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow copy of the sequencer. It is advanced once for every item beat that the
    // block accepts, so the stimulus can also look at it to decide what to send next.
    logic [2:0]  seq_phase     = i2cmrt_pkg::PH_IDLE;
    logic [6:0]  seq_addr      = '0;
    logic        seq_read      = 1'b0;
    logic [31:0] seq_subaddr   = '0;
    logic [2:0]  seq_sub_left  = '0;
    logic [15:0] seq_bytes_left = '0;

    // Bus command beats that the block still owes us, oldest first.
    i2cmrt_pkg::result_t pending_bus_beats[$];

    bit idling_on   = 1'b1;
    int items_sent  = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Ending a transfer: stop on the bus, final status attached, back to idle.
    function automatic i2cmrt_pkg::result_t stop_beat(input logic [2:0] st);
        i2cmrt_pkg::result_t r;
        r          = '0;
        r.cmd      = i2cmrt_pkg::CMD_STOP;
        r.status   = st;
        r.done_res = 1'b1;
        seq_phase  = i2cmrt_pkg::PH_IDLE;
        return r;
    endfunction

    // Entering the data phase once addressing is complete. A zero count goes straight to
    // stop; a read asks for the first byte, with NAK when it is also the last one; a
    // write sends the byte offered with the event.
    function automatic i2cmrt_pkg::result_t data_phase_beat(input logic [7:0] tx);
        i2cmrt_pkg::result_t r;
        r = '0;
        if (seq_bytes_left == 16'd0)
        begin
            r = stop_beat(i2cmrt_pkg::ST_OK);
        end
        else if (seq_read)
        begin
            seq_phase  = i2cmrt_pkg::PH_READ;
            r.cmd      = i2cmrt_pkg::CMD_RECV;
            r.nak_next = (seq_bytes_left == 16'd1);
        end
        else
        begin
            seq_phase  = i2cmrt_pkg::PH_WRITE;
            r.cmd      = i2cmrt_pkg::CMD_SEND;
            r.bus_byte = tx;
        end
        return r;
    endfunction

    // Works out the bus command beat that one accepted item beat causes, if any, and
    // queues it for the checker.
    task automatic predict_bus_command(input i2cmrt_pkg::item_t it);
        i2cmrt_pkg::result_t r;
        logic [2:0]          err;
        logic [2:0]          nsub;
        r = '0;
        if (it.op == i2cmrt_pkg::OP_START)
        begin
            // A request in the middle of a transfer is dropped silently.
            if (seq_phase != i2cmrt_pkg::PH_IDLE)
                return;
            if (it.bus_busy)
            begin
                // Bounced: a single beat with no bus command and status busy.
                r.status   = i2cmrt_pkg::ST_BUSY;
                r.done_res = 1'b1;
            end
            else
            begin
                nsub           = (it.sub_addr_bytes > SUB_MAX) ? SUB_MAX : it.sub_addr_bytes;
                seq_addr       = it.slave_addr;
                seq_read       = it.is_read;
                seq_subaddr    = it.sub_addr;
                seq_sub_left   = nsub;
                seq_bytes_left = it.data_count;
                seq_phase      = i2cmrt_pkg::PH_ADDR;
                // A read with a subaddress must first write that subaddress, so the
                // opening address byte only carries the read bit when there is none.
                r.cmd      = i2cmrt_pkg::CMD_START;
                r.bus_byte = {it.slave_addr, it.is_read && (nsub == 3'd0)};
            end
            pending_bus_beats.push_back(r);
            return;
        end

        // Byte events while idle are dropped.
        if (seq_phase == i2cmrt_pkg::PH_IDLE)
            return;

        // Arbitration loss takes priority over a missing acknowledge.
        err = it.arb_lost ? i2cmrt_pkg::ST_ARB
            : (it.nak_seen ? i2cmrt_pkg::ST_NAK : i2cmrt_pkg::ST_OK);

        case (seq_phase) inside
            i2cmrt_pkg::PH_ADDR, i2cmrt_pkg::PH_SUB:
            begin
                if (err != i2cmrt_pkg::ST_OK)
                begin
                    r = stop_beat(err);
                end
                else if (seq_sub_left != 3'd0)
                begin
                    // Subaddress goes out most significant byte first.
                    seq_sub_left = seq_sub_left - 3'd1;
                    seq_phase    = i2cmrt_pkg::PH_SUB;
                    r.cmd        = i2cmrt_pkg::CMD_SEND;
                    r.bus_byte   = 8'(seq_subaddr >> (8 * seq_sub_left));
                end
                else if (seq_phase == i2cmrt_pkg::PH_SUB && seq_read)
                begin
                    seq_phase  = i2cmrt_pkg::PH_RSTART;
                    r.cmd      = i2cmrt_pkg::CMD_RSTART;
                    r.bus_byte = {seq_addr, 1'b1};
                end
                else
                begin
                    r = data_phase_beat(it.tx_byte);
                end
            end
            i2cmrt_pkg::PH_RSTART:
            begin
                // Any trouble on the read address is reported as address NAK.
                if (err != i2cmrt_pkg::ST_OK)
                    r = stop_beat(i2cmrt_pkg::ST_ADDRNAK);
                else
                    r = data_phase_beat(it.tx_byte);
            end
            i2cmrt_pkg::PH_WRITE:
            begin
                // An error on a data byte ends the transfer, yet the status stays ok.
                seq_bytes_left = seq_bytes_left - 16'd1;
                if (err != i2cmrt_pkg::ST_OK || seq_bytes_left == 16'd0)
                begin
                    r = stop_beat(i2cmrt_pkg::ST_OK);
                end
                else
                begin
                    r.cmd      = i2cmrt_pkg::CMD_SEND;
                    r.bus_byte = it.tx_byte;
                end
            end
            i2cmrt_pkg::PH_READ:
            begin
                // Acknowledge and arbitration flags play no part while reading.
                seq_bytes_left = seq_bytes_left - 16'd1;
                r.rx_data      = it.rx_byte;
                r.rx_valid     = 1'b1;
                if (seq_bytes_left == 16'd0)
                begin
                    r.cmd      = i2cmrt_pkg::CMD_STOP;
                    r.done_res = 1'b1;
                    seq_phase  = i2cmrt_pkg::PH_IDLE;
                end
                else
                begin
                    r.cmd      = i2cmrt_pkg::CMD_RECV;
                    r.nak_next = (seq_bytes_left == 16'd1);
                end
            end
            default:
            begin
                seq_phase = i2cmrt_pkg::PH_IDLE;
                return;
            end
        endcase
        pending_bus_beats.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Item beats
    // ------------------------------------------------------------------

    function automatic i2cmrt_pkg::item_t noise_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(i2cmrt_pkg::item_t)-1:0];
    endfunction

    // The fields that the block ignores for a given kind of item are left random.
    function automatic i2cmrt_pkg::item_t make_request(input logic [6:0] addr,
                                                       input logic rd,
                                                       input logic [31:0] sub,
                                                       input logic [2:0] nsub,
                                                       input logic [15:0] count,
                                                       input logic busy);
        i2cmrt_pkg::item_t it;
        it                = noise_item();
        it.op             = i2cmrt_pkg::OP_START;
        it.slave_addr     = addr;
        it.is_read        = rd;
        it.sub_addr       = sub;
        it.sub_addr_bytes = nsub;
        it.data_count     = count;
        it.bus_busy       = busy;
        return it;
    endfunction

    function automatic i2cmrt_pkg::item_t make_event(input logic nak, input logic arb,
                                                     input logic [7:0] rx,
                                                     input logic [7:0] tx);
        i2cmrt_pkg::item_t it;
        it          = noise_item();
        it.op       = i2cmrt_pkg::OP_BYTE;
        it.nak_seen = nak;
        it.arb_lost = arb;
        it.rx_byte  = rx;
        it.tx_byte  = tx;
        return it;
    endfunction

    // Presents one item beat from a falling edge, sometimes after a burst of idle cycles,
    // and holds it until the block accepts it at a rising edge. Valid stays high after
    // acceptance, so consecutive calls without a gap give back-to-back beats.
    task automatic send_item(input i2cmrt_pkg::item_t it);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap        = $urandom_range(1, 14);
            item_valid = 1'b0;
            item       = noise_item();
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        item       = it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        predict_bus_command(it);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string beat_text(input i2cmrt_pkg::result_t r);
        return $sformatf("cmd %0d byte %02h nak_next %0b rx %02h valid %0b status %0d done %0b",
                         r.cmd, r.bus_byte, r.nak_next, r.rx_data, r.rx_valid, r.status,
                         r.done_res);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Every result beat taken from the block is matched against the oldest prediction.
    always @(posedge clk)
    begin
        i2cmrt_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_bus_beats.size() == 0)
            begin
                note_failure($sformatf("unexpected result beat: %s", beat_text(result)));
            end
            else
            begin
                want = pending_bus_beats.pop_front();
                if (result.cmd !== want.cmd || result.bus_byte !== want.bus_byte
                    || result.nak_next !== want.nak_next || result.rx_data !== want.rx_data
                    || result.rx_valid !== want.rx_valid || result.status !== want.status
                    || result.done_res !== want.done_res)
                    note_failure($sformatf("result mismatch: expected %s, got %s",
                                           beat_text(want), beat_text(result)));
            end
        end
    end

    // The receiving side holds off the block in random bursts while idling is on.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                result_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall = 1'b0;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("i2c_master_register_transfer_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A start request on a busy bus is bounced with a single beat, and a byte event with
    // no transfer running is simply dropped.
    task automatic test_request_rejection();
        send_item(make_request(7'h7F, 1'b1, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1));
        send_item(make_event(1'b1, 1'b1, 8'hFF, 8'hFF));
    endtask

    task automatic test_write_sequences();
        // Zero data count: the address byte, then stop straight away.
        send_item(make_request(7'h00, 1'b0, 32'h0000_0000, 3'd0, 16'd0, 1'b0));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        // Seven subaddress bytes are cut back to the maximum of four; one data byte.
        send_item(make_request(7'h7F, 1'b0, 32'hA5C3_0FF0, 3'd7, 16'd1, 1'b0));
        repeat (5) send_item(make_event(1'b0, 1'b0, 8'h00, 8'hFF));
        send_item(make_event(1'b0, 1'b0, 8'hFF, 8'h00));
    endtask

    task automatic test_read_sequences();
        // Read behind a subaddress: written first, then a repeated start with the read
        // bit. The flags on the next event end it with address NAK; the last event is dropped.
        send_item(make_request(7'h55, 1'b1, 32'h1234_56E7, 3'd1, 16'd2, 1'b0));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        send_item(make_event(1'b1, 1'b1, 8'h00, 8'hFF));
        send_item(make_event(1'b1, 1'b1, 8'hFF, 8'h00));
        // Without a subaddress the opening address byte already carries the read bit.
        send_item(make_request(7'h2B, 1'b1, 32'hFFFF_FFFF, 3'd0, 16'd1, 1'b0));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        send_item(make_event(1'b0, 1'b0, 8'hC3, 8'h00));
    endtask

    task automatic test_error_handling();
        // Arbitration loss and NAK together on the address byte: arbitration wins.
        send_item(make_request(7'h2A, 1'b0, 32'h0000_BEEF, 3'd2, 16'd3, 1'b0));
        send_item(make_event(1'b1, 1'b1, 8'h00, 8'h00));
        // NAK on the repeated start reports address NAK.
        send_item(make_request(7'h3C, 1'b1, 32'h0000_0077, 3'd1, 16'd4, 1'b0));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h00));
        send_item(make_event(1'b1, 1'b0, 8'h00, 8'h00));
        // NAK on a data byte stops the write but the status is still ok. A new request
        // arriving mid-transfer is dropped.
        send_item(make_request(7'h60, 1'b0, 32'h0, 3'd0, 16'd3, 1'b0));
        send_item(make_event(1'b0, 1'b0, 8'h00, 8'h5A));
        send_item(make_request(7'h01, 1'b1, 32'h0, 3'd0, 16'd1, 1'b0));
        send_item(make_event(1'b1, 1'b0, 8'h00, 8'hA5));
    endtask

    // One transfer with random content, mostly well formed and carried through to its
    // stop, with occasional stray events, bounced or mid-transfer requests and errors.
    task automatic run_random_transfer();
        logic        rd;
        logic [2:0]  nsub;
        logic [2:0]  nsub_sat;
        logic [15:0] count;
        logic        nak;
        logic        arb;
        int          pick;
        int          abort_at;
        int          n_events;
        if ($urandom_range(0, 19) == 0)
            send_item(make_event(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
        rd       = 1'($urandom);
        nsub     = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        nsub_sat = (nsub > SUB_MAX) ? SUB_MAX : nsub;
        pick     = $urandom_range(0, 19);
        if (pick == 0)
            count = 16'($urandom_range(9, 65535));
        else if (pick < 3)
            count = 16'd0;
        else
            count = 16'($urandom_range(1, 6));
        // Long transfers are cut short by a forced error. Reads ignore errors once they
        // are receiving, so theirs must land while the address or subaddress goes out.
        abort_at = -1;
        if (count > 16'd8)
            abort_at = rd ? $urandom_range(0, nsub_sat) : $urandom_range(0, nsub_sat + 6);
        send_item(make_request(7'($urandom), rd, $urandom, nsub, count,
                               $urandom_range(0, 19) == 0));
        n_events = 0;
        while (seq_phase != i2cmrt_pkg::PH_IDLE)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(make_request(7'($urandom), 1'($urandom), $urandom, 3'($urandom),
                                       16'($urandom), 1'($urandom)));
            if (n_events == abort_at)
            begin
                pick = $urandom_range(1, 3);
                nak  = pick[0];
                arb  = pick[1];
            end
            else if (seq_phase == i2cmrt_pkg::PH_READ || $urandom_range(0, 24) == 0)
            begin
                nak = 1'($urandom);
                arb = 1'($urandom);
            end
            else
            begin
                nak = 1'b0;
                arb = 1'b0;
            end
            send_item(make_event(nak, arb, 8'($urandom), 8'($urandom)));
            n_events++;
        end
    endtask

    task automatic test_random_transfers();
        int target;
        target = items_sent + 1350;
        while (items_sent < target)
            run_random_transfer();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back_traffic();
        int target;
        idling_on = 1'b0;
        target    = items_sent + 150;
        while (items_sent < target)
            run_random_transfer();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_request_rejection();
        test_write_sequences();
        test_read_sequences();
        test_error_handling();
        test_random_transfers();
        test_back_to_back_traffic();

        @(negedge clk);
        item_valid = 1'b0;
        // Drain what is still owed, then give the two-stage pipeline time to show any
        // stray beat before deciding.
        while (pending_bus_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("i2c_master_register_transfer_tb passed");
        else
            $display("i2c_master_register_transfer_tb failed");
        $finish;
    end

endmodule
